>>> hw/rtl/lrc_pkg.sv
// ----------------------------------------------------------------------------
// lrc_pkg
// Shared constants for the tagged LRU cache directory: geometry, field widths
// and item codes.
// ----------------------------------------------------------------------------
package lrc_pkg;

  localparam int unsigned ENTRIES = 256;
  localparam int unsigned IDX_W   = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
  // Scan counter has to hold ENTRIES itself.
  localparam int unsigned CNT_W   = $clog2(ENTRIES + 1);
  // Width used to compare an 8-bit release slot against ENTRIES.
  localparam int unsigned REL_W   = (CNT_W > 8) ? CNT_W : 8;

  localparam int unsigned FONT_W  = 4;
  localparam int unsigned COLOR_W = 24;
  localparam int unsigned TAG_W   = 64;
  localparam int unsigned STAMP_W = 32;
  localparam int unsigned SLOT_W  = 8;
  localparam int unsigned KEY_W   = FONT_W + COLOR_W + TAG_W;

  localparam logic [STAMP_W-1:0] STAMP_MAX = 32'hFFFF_FFFF;

  localparam logic ACT_LOOKUP  = 1'b0;
  localparam logic ACT_RELEASE = 1'b1;

endpackage

>>> hw/rtl/lru_tagged_cache_lookup_core.sv
// ----------------------------------------------------------------------------
// lru_tagged_cache_lookup_core
// Fully associative cache directory with timestamp LRU replacement.
// ----------------------------------------------------------------------------
// The input channel carries one beat per request: a lookup (font, color and
// text tag) or a release of one slot. The output channel returns exactly one
// beat per request with hit, slot and evicted.
//
// A lookup walks the directory one entry per cycle through a single key
// compare and stamp compare unit fed from the registered read port of the
// entry memory. A hit stops the walk early; a miss walks all ENTRIES entries
// and then fills the chosen slot; a release skips the walk. The walk length is
// set by the single memory read port.
//
// in_ready_o is high only while no request is in progress, so one request is
// handled at a time. A finished result sits in the output register; the next
// request may be accepted while it waits, and it holds its own result until
// the receiver takes the earlier beat. Reset clears all valid bits and the
// use counter at once; no clearing pass is needed.
// ----------------------------------------------------------------------------
module lru_tagged_cache_lookup_core (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       in_valid_i,
  output logic                       in_ready_o,
  input  logic                       action_i,
  input  logic [lrc_pkg::FONT_W-1:0] font_id_i,
  input  logic [7:0]                 red_i,
  input  logic [7:0]                 green_i,
  input  logic [7:0]                 blue_i,
  input  logic [lrc_pkg::TAG_W-1:0]  text_tag_i,
  input  logic [lrc_pkg::SLOT_W-1:0] release_slot_i,
  output logic                       out_valid_o,
  input  logic                       out_ready_i,
  output logic                       hit_o,
  output logic [lrc_pkg::SLOT_W-1:0] slot_o,
  output logic                       evicted_o
);
  import lrc_pkg::*;

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_SCAN = 2'd1;
  localparam logic [1:0] ST_FILL = 2'd2;
  localparam logic [1:0] ST_DONE = 2'd3;

  logic [1:0]         state_q, state_d;
  logic [ENTRIES-1:0] valid_q, valid_d;
  logic [STAMP_W-1:0] counter_q, counter_d;
  logic [KEY_W-1:0]   key_q, key_d;
  logic [CNT_W-1:0]   rd_idx_q, rd_idx_d;
  logic               chk_vld_q, chk_vld_d;
  logic [IDX_W-1:0]   chk_idx_q, chk_idx_d;
  logic               have_free_q, have_free_d;
  logic [IDX_W-1:0]   free_idx_q, free_idx_d;
  logic [STAMP_W-1:0] oldest_q, oldest_d;
  logic [IDX_W-1:0]   oldest_idx_q, oldest_idx_d;
  logic               res_hit_q, res_hit_d;
  logic [SLOT_W-1:0]  res_slot_q, res_slot_d;
  logic               res_evict_q, res_evict_d;
  logic               out_valid_q, out_valid_d;
  logic               out_hit_q, out_hit_d;
  logic [SLOT_W-1:0]  out_slot_q, out_slot_d;
  logic               out_evict_q, out_evict_d;

  // Entry memory: key and stamp kept apart so a hit rewrites the stamp only.
  logic [KEY_W-1:0]   key_mem [ENTRIES];
  logic [STAMP_W-1:0] stamp_mem [ENTRIES];
  logic [KEY_W-1:0]   key_rd_q;
  logic [STAMP_W-1:0] stamp_rd_q;

  logic               rd_en;
  logic [IDX_W-1:0]   rd_addr;
  logic               key_we;
  logic               stamp_we;
  logic [IDX_W-1:0]   wr_addr;
  logic [STAMP_W-1:0] wr_stamp;

  logic               in_fire;
  logic [REL_W-1:0]   rel_ext;
  logic               entry_valid;
  logic               key_match;
  logic               stamp_older;
  logic [IDX_W-1:0]   victim;

  assign in_ready_o  = (state_q == ST_IDLE);
  assign in_fire     = in_valid_i && in_ready_o;
  assign rel_ext     = REL_W'(release_slot_i);
  assign entry_valid = valid_q[chk_idx_q];
  assign key_match   = (key_rd_q == key_q);
  assign stamp_older = (stamp_rd_q < oldest_q);
  assign victim      = have_free_q ? free_idx_q : oldest_idx_q;

  assign out_valid_o = out_valid_q;
  assign hit_o       = out_hit_q;
  assign slot_o      = out_slot_q;
  assign evicted_o   = out_evict_q;

  always_comb begin
    state_d      = state_q;
    valid_d      = valid_q;
    counter_d    = counter_q;
    key_d        = key_q;
    rd_idx_d     = rd_idx_q;
    chk_vld_d    = 1'b0;
    chk_idx_d    = chk_idx_q;
    have_free_d  = have_free_q;
    free_idx_d   = free_idx_q;
    oldest_d     = oldest_q;
    oldest_idx_d = oldest_idx_q;
    res_hit_d    = res_hit_q;
    res_slot_d   = res_slot_q;
    res_evict_d  = res_evict_q;
    out_valid_d  = out_valid_q;
    out_hit_d    = out_hit_q;
    out_slot_d   = out_slot_q;
    out_evict_d  = out_evict_q;
    rd_en        = 1'b0;
    rd_addr      = rd_idx_q[IDX_W-1:0];
    key_we       = 1'b0;
    stamp_we     = 1'b0;
    wr_addr      = victim;
    wr_stamp     = counter_q;

    if (out_valid_q && out_ready_i) begin
      out_valid_d = 1'b0;
    end

    unique case (state_q)
      ST_IDLE: begin
        if (in_fire) begin
          counter_d = counter_q + 1'b1;
          if (action_i == ACT_RELEASE) begin
            if (rel_ext < REL_W'(ENTRIES)) begin
              valid_d[rel_ext[IDX_W-1:0]] = 1'b0;
            end
            res_hit_d   = 1'b0;
            res_slot_d  = release_slot_i;
            res_evict_d = 1'b0;
            state_d     = ST_DONE;
          end else begin
            key_d        = {font_id_i, red_i, green_i, blue_i, text_tag_i};
            rd_idx_d     = '0;
            have_free_d  = 1'b0;
            free_idx_d   = '0;
            oldest_d     = STAMP_MAX;
            oldest_idx_d = '0;
            state_d      = ST_SCAN;
          end
        end
      end
      ST_SCAN: begin
        // Issue the read of one entry while the previous one is checked.
        if (rd_idx_q < CNT_W'(ENTRIES)) begin
          rd_en     = 1'b1;
          chk_vld_d = 1'b1;
          chk_idx_d = rd_idx_q[IDX_W-1:0];
          rd_idx_d  = rd_idx_q + 1'b1;
        end
        if (chk_vld_q) begin
          if (!entry_valid) begin
            if (!have_free_q) begin
              have_free_d = 1'b1;
              free_idx_d  = chk_idx_q;
            end
          end else if (key_match) begin
            stamp_we    = 1'b1;
            wr_addr     = chk_idx_q;
            res_hit_d   = 1'b1;
            res_slot_d  = SLOT_W'(chk_idx_q);
            res_evict_d = 1'b0;
            chk_vld_d   = 1'b0;
            state_d     = ST_DONE;
          end else if (stamp_older) begin
            oldest_d     = stamp_rd_q;
            oldest_idx_d = chk_idx_q;
          end
          if (!(entry_valid && key_match) && chk_idx_q == IDX_W'(ENTRIES - 1)) begin
            state_d = ST_FILL;
          end
        end
      end
      ST_FILL: begin
        key_we           = 1'b1;
        stamp_we         = 1'b1;
        wr_addr          = victim;
        valid_d[victim]  = 1'b1;
        res_hit_d        = 1'b0;
        res_slot_d       = SLOT_W'(victim);
        res_evict_d      = valid_q[victim];
        state_d          = ST_DONE;
      end
      ST_DONE: begin
        if (!out_valid_q || out_ready_i) begin
          out_valid_d = 1'b1;
          out_hit_d   = res_hit_q;
          out_slot_d  = res_slot_q;
          out_evict_d = res_evict_q;
          state_d     = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      valid_q     <= '0;
      counter_q   <= '0;
      chk_vld_q   <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      valid_q     <= valid_d;
      counter_q   <= counter_d;
      chk_vld_q   <= chk_vld_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    key_q        <= key_d;
    rd_idx_q     <= rd_idx_d;
    chk_idx_q    <= chk_idx_d;
    have_free_q  <= have_free_d;
    free_idx_q   <= free_idx_d;
    oldest_q     <= oldest_d;
    oldest_idx_q <= oldest_idx_d;
    res_hit_q    <= res_hit_d;
    res_slot_q   <= res_slot_d;
    res_evict_q  <= res_evict_d;
    out_hit_q    <= out_hit_d;
    out_slot_q   <= out_slot_d;
    out_evict_q  <= out_evict_d;
  end

  always_ff @(posedge clk_i) begin
    if (key_we) begin
      key_mem[wr_addr] <= key_q;
    end
    if (stamp_we) begin
      stamp_mem[wr_addr] <= wr_stamp;
    end
    if (rd_en) begin
      key_rd_q   <= key_mem[rd_addr];
      stamp_rd_q <= stamp_mem[rd_addr];
    end
  end

endmodule
